@@ hdl/mkpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mkpd_pkg - shared types and constants for the keypad scanner
// Matrix geometry, key tracker states, request kinds and register indexes.
// ----------------------------------------------------------------------------
package mkpd_pkg;

  localparam int ROWS     = 4;
  localparam int COLUMNS  = 4;
  localparam int MAX_KEYS = 16;
  localparam int NUM_KEYS = (ROWS * COLUMNS > MAX_KEYS) ? MAX_KEYS : ROWS * COLUMNS;

  localparam int CODE_W      = 8;
  localparam int LEVELS_W    = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODES_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODES_HIGH = 8'd1;

  localparam logic [CFG_DATA_W-1:0] KEY_CODES_LOW_RST  = 64'h0807060504030201;
  localparam logic [CFG_DATA_W-1:0] KEY_CODES_HIGH_RST = 64'h100F0E0D0C0B0A09;

  // request kinds carried in tuser
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    TRK_INIT     = 2'd0,
    TRK_PRESSED  = 2'd1,
    TRK_RELEASED = 2'd2
  } trk_t;

  typedef struct packed {
    trk_t state_next;
    logic hit;          // pressed and seen low again
  } lane_out_t;

endpackage

@@ hdl/matrix_keypad_scan_debounce.sv @@
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce - keypad scanner with per-key debounce
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   tdata: key_levels; tuser: req_type
//   m_*      out  m_tvalid/m_tready   tdata: read_key, current_key, fresh_flag
//   cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (key code tables)
//
// One item per cycle: all key lanes are evaluated in the same cycle, the merge
// applies the priority cut-off. Each result is registered into a two-entry
// output queue on its transfer, so input keeps flowing while a result waits.
// s_tready drops only when both queue entries are held by a stalled consumer.
// rst (synchronous) clears trackers, latched code, flag and queue and loads
// the default code tables. cfg_ready is always high.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mkpd_pkg::LEVELS_W-1:0]      s_tdata,   // [15:0] key_levels
  input  logic                               s_tuser,   // [0] req_type
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mkpd_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [7:0] read_key,
                                                        // [15:8] current_key,
                                                        // [16] fresh_flag
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mkpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mkpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mkpd_pkg::*;

  // configuration
  logic [CFG_DATA_W-1:0] key_codes_low;
  logic [CFG_DATA_W-1:0] key_codes_high;
  logic [2*CFG_DATA_W-1:0] code_table;

  // scan state
  trk_t             tracker [NUM_KEYS];
  logic [CODE_W-1:0] latched_key;
  logic              new_value_flag;

  // lane wiring
  logic [CODE_W-1:0]   codes [NUM_KEYS];
  lane_out_t           lane_out [NUM_KEYS];
  logic [NUM_KEYS-1:0] hits;
  logic [NUM_KEYS-1:0] enable;
  logic [CODE_W-1:0]   found;

  // item result
  logic               s_xfer;
  logic               m_xfer;
  logic               is_scan;
  logic [CODE_W-1:0]  latched_key_next;
  logic               new_value_flag_next;
  logic [CODE_W-1:0]  read_key;
  logic [OUT_TDATA_W-1:0] result;

  // output queue
  logic [1:0]             count;
  logic [OUT_TDATA_W-1:0] head;
  logic [OUT_TDATA_W-1:0] skid;

  assign cfg_ready  = 1'b1;
  assign code_table = {key_codes_high, key_codes_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_codes_low  <= KEY_CODES_LOW_RST;
      key_codes_high <= KEY_CODES_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_KEY_CODES_LOW)  key_codes_low  <= cfg_data;
      if (cfg_index == CFG_KEY_CODES_HIGH) key_codes_high <= cfg_data;
    end
  end

  // one lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    assign codes[k] = code_table[k*CODE_W +: CODE_W];
    assign hits[k]  = lane_out[k].hit;

    mkpd_lane u_lane (
      .state    (tracker[k]),
      .low      (s_tdata[k]),
      .enable   (enable[k]),
      .lane_out (lane_out[k])
    );
  end

  mkpd_merge u_merge (
    .hits   (hits),
    .codes  (codes),
    .enable (enable),
    .found  (found)
  );

  assign s_xfer  = s_tvalid && s_tready;
  assign m_xfer  = m_tvalid && m_tready;
  assign is_scan = (s_tuser == REQ_SCAN);

  always_comb begin
    latched_key_next    = latched_key;
    new_value_flag_next = new_value_flag;
    read_key            = '0;
    if (is_scan) begin
      if (found != latched_key) begin
        latched_key_next    = found;
        new_value_flag_next = 1'b1;
      end
    end else if (new_value_flag && (latched_key != '0)) begin
      // hand the code out once; a zero code leaves the flag set
      read_key            = latched_key;
      new_value_flag_next = 1'b0;
    end
  end

  assign result = {{(OUT_TDATA_W - 2*CODE_W - 1){1'b0}},
                   new_value_flag_next, latched_key_next, read_key};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) tracker[k] <= TRK_INIT;
      latched_key    <= '0;
      new_value_flag <= 1'b0;
    end else if (s_xfer) begin
      if (is_scan) begin
        for (int k = 0; k < NUM_KEYS; k++) tracker[k] <= lane_out[k].state_next;
      end
      latched_key    <= latched_key_next;
      new_value_flag <= new_value_flag_next;
    end
  end

  // two-entry output queue: head drives m_tdata, skid holds the second
  assign s_tready = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({s_xfer, m_xfer})
        2'b10: begin
          if (count == 2'd0) head <= result;
          else skid <= result;
          count <= count + 2'd1;
        end
        2'b01: begin
          if (count == 2'd2) head <= skid;
          count <= count - 2'd1;
        end
        2'b11: begin
          if (count == 2'd1) begin
            head <= result;
          end else begin
            head <= skid;
            skid <= result;
          end
        end
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/mkpd_lane.sv @@
// ----------------------------------------------------------------------------
// mkpd_lane - debounce tracker of one key
// Next tracker state and hit flag for one key of a scan snapshot.
// ----------------------------------------------------------------------------
module mkpd_lane (
  input  mkpd_pkg::trk_t      state,
  input  logic                low,
  input  logic                enable,   // not cut off by an earlier key
  output mkpd_pkg::lane_out_t lane_out
);
  import mkpd_pkg::*;

  trk_t step;

  always_comb begin
    step = state;
    case (state)
      TRK_INIT:     step = low ? TRK_PRESSED : TRK_RELEASED;
      TRK_PRESSED:  step = low ? TRK_PRESSED : TRK_RELEASED;
      TRK_RELEASED: step = low ? TRK_PRESSED : TRK_RELEASED;
      default:      step = state;
    endcase
  end

  assign lane_out.state_next = enable ? step : state;
  assign lane_out.hit        = (state == TRK_PRESSED) && low;

endmodule

@@ hdl/mkpd_merge.sv @@
// ----------------------------------------------------------------------------
// mkpd_merge - priority cut-off across key lanes
// Picks the first hit with a nonzero code; later lanes are held.
// ----------------------------------------------------------------------------
module mkpd_merge (
  input  logic [mkpd_pkg::NUM_KEYS-1:0] hits,
  input  logic [mkpd_pkg::CODE_W-1:0]   codes [mkpd_pkg::NUM_KEYS],
  output logic [mkpd_pkg::NUM_KEYS-1:0] enable,
  output logic [mkpd_pkg::CODE_W-1:0]   found
);
  import mkpd_pkg::*;

  logic [NUM_KEYS:0] blocked;
  logic [NUM_KEYS-1:0] stop;

  always_comb begin
    blocked[0] = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      stop[k]      = hits[k] && (codes[k] != '0);
      blocked[k+1] = blocked[k] | stop[k];
      enable[k]    = !blocked[k];
    end
  end

  // at most one lane is both stopping and unblocked: and-or select
  always_comb begin
    found = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (stop[k] && !blocked[k]) found = found | codes[k];
    end
  end

endmodule
